[hdl/blpg_pkg.sv]
// ----------------------------------------------------------------------------
// blpg_pkg: shared types and constants for the line pixel generator
// Holds the screen geometry, colour codes and the command passed from the
// front classifier to the line walker.
// ----------------------------------------------------------------------------
`default_nettype none

package blpg_pkg;

  localparam int SCREEN_WIDTH  = 128;
  localparam int SCREEN_HEIGHT = 64;
  localparam int QUEUE_DEPTH   = 2;

  localparam int CoordW = 11;
  localparam int DeltaW = 12;
  localparam int ErrW   = 13;

  localparam logic OP_START = 1'b0;
  localparam logic OP_STEP  = 1'b1;

  localparam logic [1:0] COLOR_NONE = 2'd0;

  typedef struct packed {
    logic                     is_start;
    logic                     steep;
    logic signed [CoordW-1:0] major_pos;
    logic signed [DeltaW-1:0] minor_pos;
    logic signed [CoordW-1:0] major_end;
    logic [DeltaW-1:0]        major_delta;
    logic [DeltaW-1:0]        minor_delta;
    logic                     minor_dir;
    logic [1:0]               color;
  } blpg_cmd_t;

endpackage

`default_nettype wire

[hdl/blpg_front.sv]
// ----------------------------------------------------------------------------
// blpg_front: input classifier
// Accepts start and step items and turns a start item into ordered
// major/minor endpoints, deltas and the minor step direction.
// ----------------------------------------------------------------------------
`default_nettype none

module blpg_front (
  input  wire logic              s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  input  wire logic [47:0]       s_axis_tdata_i,   // start_x, start_y, end_x, end_y, color_mode
  input  wire logic              s_axis_tuser_i,   // op
  output logic                   cmd_valid_o,
  input  wire logic              cmd_ready_i,
  output blpg_pkg::blpg_cmd_t    cmd_o
);
  import blpg_pkg::*;

  logic signed [CoordW-1:0] ax, ay, bx, by;
  logic signed [DeltaW-1:0] dx, dy, dmaj, dmin;
  logic [DeltaW-1:0]        adx, ady;
  logic                     steep, neg;
  logic signed [CoordW-1:0] maj_a, maj_b, min_a, min_b;

  assign ax = s_axis_tdata_i[10:0];
  assign ay = s_axis_tdata_i[21:11];
  assign bx = s_axis_tdata_i[32:22];
  assign by = s_axis_tdata_i[43:33];

  assign dx  = DeltaW'(bx) - DeltaW'(ax);
  assign dy  = DeltaW'(by) - DeltaW'(ay);
  assign adx = dx[DeltaW-1] ? DeltaW'(-dx) : DeltaW'(dx);
  assign ady = dy[DeltaW-1] ? DeltaW'(-dy) : DeltaW'(dy);

  assign steep = ady > adx;
  assign maj_a = steep ? ay : ax;
  assign maj_b = steep ? by : bx;
  assign min_a = steep ? ax : ay;
  assign min_b = steep ? bx : by;
  assign dmaj  = steep ? dy : dx;
  assign dmin  = steep ? dx : dy;
  assign neg   = dmaj[DeltaW-1];

  always_comb begin
    cmd_o = '0;
    if (s_axis_tuser_i == OP_START) begin
      cmd_o.is_start    = 1'b1;
      cmd_o.steep       = steep;
      cmd_o.major_pos   = neg ? maj_b : maj_a;
      cmd_o.major_end   = neg ? maj_a : maj_b;
      cmd_o.minor_pos   = DeltaW'(neg ? min_b : min_a);
      cmd_o.major_delta = steep ? ady : adx;
      cmd_o.minor_delta = steep ? adx : ady;
      cmd_o.minor_dir   = neg ? !dmin[DeltaW-1] : (dmin[DeltaW-1] || (dmin == '0));
      cmd_o.color       = s_axis_tdata_i[45:44];
    end
  end

  assign cmd_valid_o     = s_axis_tvalid_i;
  assign s_axis_tready_o = cmd_ready_i;

endmodule

`default_nettype wire

[hdl/blpg_queue.sv]
// ----------------------------------------------------------------------------
// blpg_queue: command queue
// Short first-in first-out buffer between the classifier and the walker.
// ----------------------------------------------------------------------------
`default_nettype none

module blpg_queue #(
  parameter int Depth = blpg_pkg::QUEUE_DEPTH
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                wr_valid_i,
  output logic                     wr_ready_o,
  input  wire blpg_pkg::blpg_cmd_t wr_data_i,
  output logic                     rd_valid_o,
  input  wire logic                rd_ready_i,
  output blpg_pkg::blpg_cmd_t      rd_data_o
);
  import blpg_pkg::*;

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  blpg_cmd_t       mem_q [Depth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;

  assign wr_ready_o = count_q != FullCnt;
  assign rd_valid_o = count_q != '0;
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign push       = wr_valid_i && wr_ready_o;
  assign pop        = rd_valid_o && rd_ready_i;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

`default_nettype wire

[hdl/blpg_back.sv]
// ----------------------------------------------------------------------------
// blpg_back: line walker
// Holds the line state, loads it on a start command, performs one Bresenham
// step per step command and keeps the result in an output register.
// ----------------------------------------------------------------------------
`default_nettype none

module blpg_back (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                cmd_valid_i,
  output logic                     cmd_ready_o,
  input  wire blpg_pkg::blpg_cmd_t cmd_i,
  output logic                     m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  output logic [15:0]              m_axis_tdata_o,   // pixel_col, pixel_row, pixel_action,
                                                     // line_active
  output logic                     m_axis_tuser_o,   // pixel_valid
  output logic                     m_axis_tlast_o    // last_pixel
);
  import blpg_pkg::*;

  localparam logic signed [DeltaW-1:0] ScrW = DeltaW'(SCREEN_WIDTH);
  localparam logic signed [DeltaW-1:0] ScrH = DeltaW'(SCREEN_HEIGHT);

  logic                     active_q, active_d;
  logic                     steep_q, steep_d;
  logic signed [CoordW-1:0] major_pos_q, major_pos_d;
  logic signed [DeltaW-1:0] minor_pos_q, minor_pos_d;
  logic signed [CoordW-1:0] major_end_q, major_end_d;
  logic signed [ErrW-1:0]   error_q, error_d;
  logic [DeltaW-1:0]        major_delta_q, major_delta_d;
  logic [DeltaW-1:0]        minor_delta_q, minor_delta_d;
  logic                     minor_dir_q, minor_dir_d;
  logic [1:0]               color_q, color_d;

  logic                     out_valid_q;
  logic [15:0]              out_data_q, out_data_d;
  logic                     out_user_q, out_user_d;
  logic                     out_last_q, out_last_d;

  logic                     pop;
  logic signed [DeltaW-1:0] px, py, col_full, row_full;
  logic                     visible;
  logic signed [ErrW-1:0]   err_sub, err_add;

  assign pop         = cmd_valid_i && (!out_valid_q || m_axis_tready_i);
  assign cmd_ready_o = !out_valid_q || m_axis_tready_i;

  assign px       = steep_q ? minor_pos_q : DeltaW'(major_pos_q);
  assign py       = steep_q ? DeltaW'(major_pos_q) : minor_pos_q;
  assign visible  = !px[DeltaW-1] && !py[DeltaW-1] && (px < ScrW) && (py < ScrH);
  assign col_full = ScrW - 12'sd1 - px;
  assign row_full = ScrH - 12'sd1 - py;
  assign err_sub  = error_q - $signed({1'b0, minor_delta_q});
  assign err_add  = err_sub + $signed({1'b0, major_delta_q});

  always_comb begin
    active_d      = active_q;
    steep_d       = steep_q;
    major_pos_d   = major_pos_q;
    minor_pos_d   = minor_pos_q;
    major_end_d   = major_end_q;
    error_d       = error_q;
    major_delta_d = major_delta_q;
    minor_delta_d = minor_delta_q;
    minor_dir_d   = minor_dir_q;
    color_d       = color_q;
    out_data_d    = '0;
    out_user_d    = 1'b0;
    out_last_d    = 1'b0;
    if (cmd_i.is_start) begin
      active_d      = 1'b1;
      steep_d       = cmd_i.steep;
      major_pos_d   = cmd_i.major_pos;
      minor_pos_d   = cmd_i.minor_pos;
      major_end_d   = cmd_i.major_end;
      major_delta_d = cmd_i.major_delta;
      minor_delta_d = cmd_i.minor_delta;
      error_d       = ErrW'(cmd_i.major_delta >> 1);
      minor_dir_d   = cmd_i.minor_dir;
      color_d       = cmd_i.color;
    end else if (active_q) begin
      if (visible && (color_q != COLOR_NONE)) begin
        out_user_d        = 1'b1;
        out_data_d[6:0]   = col_full[6:0];
        out_data_d[12:7]  = row_full[5:0];
        out_data_d[14:13] = color_q - 2'd1;
      end
      if (major_pos_q >= major_end_q) begin
        out_last_d = 1'b1;
        active_d   = 1'b0;
      end else begin
        major_pos_d = major_pos_q + 11'sd1;
        if (err_sub[ErrW-1]) begin
          minor_pos_d = minor_dir_q ? minor_pos_q - 12'sd1 : minor_pos_q + 12'sd1;
          error_d     = err_add;
        end else begin
          error_d = err_sub;
        end
      end
    end
    out_data_d[15] = active_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        active_q    <= active_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop) begin
      steep_q       <= steep_d;
      major_pos_q   <= major_pos_d;
      minor_pos_q   <= minor_pos_d;
      major_end_q   <= major_end_d;
      error_q       <= error_d;
      major_delta_q <= major_delta_d;
      minor_delta_q <= minor_delta_d;
      minor_dir_q   <= minor_dir_d;
      color_q       <= color_d;
      out_data_q    <= out_data_d;
      out_user_q    <= out_user_d;
      out_last_q    <= out_last_d;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;
  assign m_axis_tlast_o  = out_last_q;

endmodule

`default_nettype wire

[hdl/bresenham_line_pixel_generator.sv]
// ----------------------------------------------------------------------------
// bresenham_line_pixel_generator: streaming Bresenham line walker
// Input items on the slave stream either start a line (tuser 0: two signed
// endpoints and a colour mode in tdata) or ask for the next pixel (tuser 1).
// Every input item gives exactly one result item on the master stream:
// tuser marks a visible pixel, tlast the final point of the line, and tdata
// carries the mirrored column and row, the framebuffer action and whether
// points of the line remain.
// A start item is classified in the front part (axis swap, endpoint order,
// deltas) and queued; the walker takes one command per cycle while the
// output is not stalled and does one error-term add and compare per step.
// An accepted input item is registered in the command queue and then in
// the output register, 1 item per cycle sustained. The two-entry command
// queue and the output register hold up to three items in all while the
// receiver stalls; once they are full tready drops until results are taken.
// Reset clears the queue, the output register and the line-active flag, so
// step items before the first start give all-zero results.
// ----------------------------------------------------------------------------
`default_nettype none

module bresenham_line_pixel_generator (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid_i,
  output logic             s_axis_tready_o,
  input  wire logic [47:0] s_axis_tdata_i,   // start_x, start_y, end_x, end_y, color_mode
  input  wire logic        s_axis_tuser_i,   // op
  output logic             m_axis_tvalid_o,
  input  wire logic        m_axis_tready_i,
  output logic [15:0]      m_axis_tdata_o,   // pixel_col, pixel_row, pixel_action, line_active
  output logic             m_axis_tuser_o,   // pixel_valid
  output logic             m_axis_tlast_o    // last_pixel
);
  import blpg_pkg::*;

  blpg_cmd_t front_cmd, queue_cmd;
  logic      front_valid, front_ready, queue_valid, queue_ready;

  blpg_front u_front (
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .cmd_valid_o     (front_valid),
    .cmd_ready_i     (front_ready),
    .cmd_o           (front_cmd)
  );

  blpg_queue #(
    .Depth (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (front_valid),
    .wr_ready_o (front_ready),
    .wr_data_i  (front_cmd),
    .rd_valid_o (queue_valid),
    .rd_ready_i (queue_ready),
    .rd_data_o  (queue_cmd)
  );

  blpg_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_valid_i     (queue_valid),
    .cmd_ready_o     (queue_ready),
    .cmd_i           (queue_cmd),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o),
    .m_axis_tuser_o  (m_axis_tuser_o),
    .m_axis_tlast_o  (m_axis_tlast_o)
  );

endmodule

`default_nettype wire

[dv/tb_bresenham_line_pixel_generator.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_bresenham_line_pixel_generator: stream testbench for the line walker
// Sends start and step items to the slave stream and predicts each result
// from its own model of the Bresenham walk: axis swap, endpoint order,
// error term, clipping to the screen and mirroring. Every result on the
// master stream is checked field by field against the oldest prediction.
// Three phases vary the idling on both sides; one long receiver stall
// fills the block so that its input stalls too.
// ----------------------------------------------------------------------------

module tb_bresenham_line_pixel_generator;
  import blpg_pkg::*;

  localparam int HoldCycles  = 60;
  localparam int StallLimit  = 5000;
  localparam int DrainCycles = 8;
  localparam int MaxReports  = 10;

  localparam logic [1:0] COLOR_INVERT = 2'd1;
  localparam logic [1:0] COLOR_WHITE  = 2'd2;
  localparam logic [1:0] COLOR_BLACK  = 2'd3;

  localparam logic [1:0] ACT_INVERT = 2'd0;
  localparam logic [1:0] ACT_SET    = 2'd1;
  localparam logic [1:0] ACT_CLEAR  = 2'd2;

  typedef struct packed {
    logic                     op;
    logic signed [CoordW-1:0] sx;
    logic signed [CoordW-1:0] sy;
    logic signed [CoordW-1:0] ex;
    logic signed [CoordW-1:0] ey;
    logic [1:0]               color;
  } line_item_t;

  typedef struct packed {
    logic       pix_valid;
    logic [6:0] col;
    logic [5:0] row;
    logic [1:0] action;
    logic       last;
    logic       active;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [47:0] s_tdata = '0;
  logic        s_tuser = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  line_item_t  pending_q[$];
  pixel_t      pixel_q[$];
  line_item_t  drv_item = '0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  bit hold_req = 1'b0;
  int hold_left = 0;
  int idle_cycles = 0;
  int mismatches = 0;
  int planned = 0;

  bit          ln_active = 1'b0;
  bit          ln_steep = 1'b0;
  int          ln_major = 0;
  int          ln_minor = 0;
  int          ln_major_end = 0;
  int          ln_err = 0;
  int          ln_major_delta = 0;
  int          ln_minor_delta = 0;
  bit          ln_minor_down = 1'b0;
  logic [1:0]  ln_color = COLOR_NONE;

  bresenham_line_pixel_generator i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  function automatic int abs_diff(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic pixel_t walk_step(line_item_t it);
    pixel_t p;
    int     ax, ay, bx, by, t, x, y;
    bit     steep;
    p = '0;
    if (it.op == OP_START) begin
      ax = $signed(it.sx);
      ay = $signed(it.sy);
      bx = $signed(it.ex);
      by = $signed(it.ey);
      steep = abs_diff(by, ay) > abs_diff(bx, ax);
      if (steep) begin
        t = ax; ax = ay; ay = t;
        t = bx; bx = by; by = t;
      end
      if (ax > bx) begin
        t = ax; ax = bx; bx = t;
        t = ay; ay = by; by = t;
      end
      ln_steep       = steep;
      ln_major       = ax;
      ln_minor       = ay;
      ln_major_end   = bx;
      ln_major_delta = bx - ax;
      ln_minor_delta = abs_diff(by, ay);
      ln_err         = ln_major_delta / 2;
      ln_minor_down  = !(ay < by);
      ln_color       = it.color;
      ln_active      = 1'b1;
    end else if (ln_active) begin
      x = ln_steep ? ln_minor : ln_major;
      y = ln_steep ? ln_major : ln_minor;
      if (x >= 0 && y >= 0 && x < SCREEN_WIDTH && y < SCREEN_HEIGHT &&
          ln_color != COLOR_NONE) begin
        p.pix_valid = 1'b1;
        p.col = 7'(SCREEN_WIDTH - 1 - x);
        p.row = 6'(SCREEN_HEIGHT - 1 - y);
        case (ln_color)
          COLOR_INVERT: p.action = ACT_INVERT;
          COLOR_WHITE:  p.action = ACT_SET;
          default:      p.action = ACT_CLEAR;
        endcase
      end
      if (ln_major >= ln_major_end) begin
        p.last = 1'b1;
        ln_active = 1'b0;
      end else begin
        ln_major = ln_major + 1;
        ln_err = ln_err - ln_minor_delta;
        if (ln_err < 0) begin
          ln_minor = ln_minor + (ln_minor_down ? -1 : 1);
          ln_err = ln_err + ln_major_delta;
        end
      end
    end
    p.active = ln_active;
    return p;
  endfunction

  function automatic line_item_t rand_item(logic op);
    line_item_t it;
    it.op    = op;
    it.sx    = CoordW'($urandom_range(2047));
    it.sy    = CoordW'($urandom_range(2047));
    it.ex    = CoordW'($urandom_range(2047));
    it.ey    = CoordW'($urandom_range(2047));
    it.color = 2'($urandom_range(3));
    return it;
  endfunction

  task automatic queue_line(int sx, int sy, int ex, int ey, logic [1:0] color, int steps);
    line_item_t it;
    it = rand_item(OP_START);
    it.sx = CoordW'(sx);
    it.sy = CoordW'(sy);
    it.ex = CoordW'(ex);
    it.ey = CoordW'(ey);
    it.color = color;
    pending_q.push_back(it);
    repeat (steps) pending_q.push_back(rand_item(OP_STEP));
    planned += steps + 1;
  endtask

  task automatic queue_random(int count);
    int r, x0, y0, x1, y1, len, steps, stop_at;
    stop_at = planned + count;
    while (planned < stop_at) begin
      r = $urandom_range(99);
      if (r < 70) begin
        x0 = $urandom_range(143) - 8;
        y0 = $urandom_range(79) - 8;
        x1 = x0 + $urandom_range(30) - 15;
        y1 = y0 + $urandom_range(30) - 15;
        len = ((abs_diff(x1, x0) > abs_diff(y1, y0)) ? abs_diff(x1, x0)
                                                     : abs_diff(y1, y0)) + 1;
        steps = len;
        if ($urandom_range(9) == 0) steps = $urandom_range(len - 1);
        else if ($urandom_range(4) == 0) steps = len + $urandom_range(2);
        queue_line(x0, y0, x1, y1, 2'($urandom_range(3)), steps);
      end else if (r < 85) begin
        pending_q.push_back(rand_item(OP_START));
        steps = $urandom_range(6);
        repeat (steps) pending_q.push_back(rand_item(OP_STEP));
        planned += steps + 1;
      end else begin
        steps = $urandom_range(3);
        repeat (steps) pending_q.push_back(rand_item(OP_STEP));
        if (steps == 0) pending_q.push_back(rand_item(OP_START));
        planned += (steps == 0) ? 1 : steps;
      end
    end
  endtask

  task automatic drain();
    while (pending_q.size() != 0 || s_tvalid || pixel_q.size() != 0) @(negedge clk_i);
  endtask

  always @(posedge clk_i) begin : driver
    line_item_t nxt;
    if (rst_ni && (!s_tvalid || s_tready)) begin
      if (pending_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        nxt = pending_q.pop_front();
        drv_item <= nxt;
        s_tdata  <= {2'b00, nxt.color, nxt.ey, nxt.ex, nxt.sy, nxt.sx};
        s_tuser  <= nxt.op;
        s_tvalid <= 1'b1;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : receiver
    if (!rst_ni) begin
      m_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else if (hold_req) begin
      hold_req <= 1'b0;
      hold_left <= HoldCycles;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk_i) begin : monitor
    pixel_t got, want;
    bit     moved;
    if (rst_ni) begin
      moved = 1'b0;
      if (s_tvalid && s_tready) begin
        pixel_q.push_back(walk_step(drv_item));
        moved = 1'b1;
      end
      if (m_tvalid && m_tready) begin
        moved = 1'b1;
        got.pix_valid = m_tuser;
        got.col       = m_tdata[6:0];
        got.row       = m_tdata[12:7];
        got.action    = m_tdata[14:13];
        got.active    = m_tdata[15];
        got.last      = m_tlast;
        if (pixel_q.size() == 0) begin
          if (mismatches < MaxReports)
            $display("unexpected result: valid=%0b col=%0d row=%0d act=%0d last=%0b act_ln=%0b",
                     got.pix_valid, got.col, got.row, got.action, got.last, got.active);
          mismatches++;
        end else begin
          want = pixel_q.pop_front();
          if (got !== want) begin
            if (mismatches < MaxReports)
              $display({"mismatch: exp valid=%0b col=%0d row=%0d act=%0d last=%0b ln=%0b",
                        " | got valid=%0b col=%0d row=%0d act=%0d last=%0b ln=%0b"},
                       want.pix_valid, want.col, want.row, want.action, want.last,
                       want.active, got.pix_valid, got.col, got.row, got.action,
                       got.last, got.active);
            mismatches++;
          end
        end
      end
      if (moved) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= StallLimit) begin
        $display("tb_bresenham_line_pixel_generator: errors");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    send_idle_pct = 15;
    recv_idle_pct = 70;
    pending_q.push_back(rand_item(OP_STEP));
    pending_q.push_back(rand_item(OP_STEP));
    queue_line(0, 0, 0, 0, COLOR_INVERT, 2);
    queue_line(-1024, -1024, 1023, 1023, COLOR_WHITE, 3);
    queue_line(127, 63, 120, 10, COLOR_BLACK, 4);
    queue_line(0, 5, 10, 5, COLOR_NONE, 2);
    queue_line(1023, -1024, -1024, 1023, COLOR_INVERT, 2);
    queue_line(130, 70, 125, 60, COLOR_WHITE, 12);
    queue_random(170);
    drain();

    send_idle_pct = 70;
    recv_idle_pct = 15;
    queue_random(170);
    drain();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    queue_random(170);
    repeat (5) @(negedge clk_i);
    hold_req = 1'b1;
    drain();

    repeat (DrainCycles) @(negedge clk_i);
    if (mismatches == 0 && pixel_q.size() == 0) begin
      $display("tb_bresenham_line_pixel_generator: clean");
    end else begin
      $display("tb_bresenham_line_pixel_generator: errors");
    end
    $finish;
  end

endmodule
